// ===== hdl/mipsdd_pkg.sv =====
// Shared types and constants for the MIPS decoder with label allocation.
// Used by mips_disassembly_decoder_with_labels; no dependencies.
package mipsdd_pkg;

	// Mnemonic codes, in listing order
	typedef enum logic [5:0] {
		MN_NOP     = 6'd0,
		MN_ERET    = 6'd1,
		MN_ADD     = 6'd2,
		MN_ADDU    = 6'd3,
		MN_AND     = 6'd4,
		MN_DIV     = 6'd5,
		MN_DIVU    = 6'd6,
		MN_JR      = 6'd7,
		MN_MFHI    = 6'd8,
		MN_MFLO    = 6'd9,
		MN_MTHI    = 6'd10,
		MN_MTLO    = 6'd11,
		MN_MULT    = 6'd12,
		MN_MULTU   = 6'd13,
		MN_OR      = 6'd14,
		MN_SLT     = 6'd15,
		MN_SLTU    = 6'd16,
		MN_SUB     = 6'd17,
		MN_SUBU    = 6'd18,
		MN_SYSCALL = 6'd19,
		MN_ADDI    = 6'd20,
		MN_ADDIU   = 6'd21,
		MN_ANDI    = 6'd22,
		MN_BEQ     = 6'd23,
		MN_BNE     = 6'd24,
		MN_LB      = 6'd25,
		MN_LH      = 6'd26,
		MN_LUI     = 6'd27,
		MN_LW      = 6'd28,
		MN_J       = 6'd29,
		MN_JAL     = 6'd30,
		MN_ORI     = 6'd31,
		MN_SB      = 6'd32,
		MN_SH      = 6'd33,
		MN_SW      = 6'd34,
		MN_MFC0    = 6'd35,
		MN_MTC0    = 6'd36,
		MN_UNKNOWN = 6'd37
	} mnem_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP
	} state_t;

	// Request kinds
	localparam logic REQ_DECODE = 1'b0;
	localparam logic REQ_READ   = 1'b1;

	localparam logic [31:0] ERET_WORD = 32'h4200_0018;

	// Primary opcodes
	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_J       = 6'h02;
	localparam logic [5:0] OP_JAL     = 6'h03;
	localparam logic [5:0] OP_BEQ     = 6'h04;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_ADDI    = 6'h08;
	localparam logic [5:0] OP_ANDI    = 6'h0C;
	localparam logic [5:0] OP_ORI     = 6'h0D;
	localparam logic [5:0] OP_LUI     = 6'h0F;
	localparam logic [5:0] OP_COP0    = 6'h10;
	localparam logic [5:0] OP_LB      = 6'h20;
	localparam logic [5:0] OP_LH      = 6'h21;
	localparam logic [5:0] OP_LW      = 6'h23;
	localparam logic [5:0] OP_SB      = 6'h28;
	localparam logic [5:0] OP_SH      = 6'h29;
	localparam logic [5:0] OP_SW      = 6'h2B;

	// SPECIAL function codes
	localparam logic [5:0] FN_JR      = 6'h08;
	localparam logic [5:0] FN_SYSCALL = 6'h0C;
	localparam logic [5:0] FN_MFHI    = 6'h10;
	localparam logic [5:0] FN_MTHI    = 6'h11;
	localparam logic [5:0] FN_MFLO    = 6'h12;
	localparam logic [5:0] FN_MTLO    = 6'h13;
	localparam logic [5:0] FN_MULT    = 6'h18;
	localparam logic [5:0] FN_MULTU   = 6'h19;
	localparam logic [5:0] FN_DIV     = 6'h1A;
	localparam logic [5:0] FN_DIVU    = 6'h1B;
	localparam logic [5:0] FN_ADD     = 6'h20;
	localparam logic [5:0] FN_SUB     = 6'h22;
	localparam logic [5:0] FN_AND     = 6'h24;
	localparam logic [5:0] FN_OR      = 6'h25;
	localparam logic [5:0] FN_SLT     = 6'h2A;
	localparam logic [5:0] FN_SLTU    = 6'h2B;

	// COP0 rs selectors
	localparam logic [4:0] CP0_MF = 5'd0;
	localparam logic [4:0] CP0_MT = 5'd4;

	localparam int          LABEL_W   = 11;
	localparam logic [10:0] LABEL_MAX = 11'h7FF;

	// Signed width holding any branch or jump target index
	localparam int TGT_W = 28;

endpackage

// ===== hdl/mips_disassembly_decoder_with_labels.sv =====
// MIPS32 instruction decoder with branch/jump label allocation.
// Top level; depends on mipsdd_pkg. Holds the label table memory.
// out_valid rises at the commit from ST_LOOKUP, after the table read;
// the commit waits while a held result blocks it.
// One request at a time; the next is taken only once the table read-modify-write commits.
// Reset: counters cleared, trap_on_overflow set; then a clearing pass writes zero
// to every table entry, with in_stall high throughout.
module mips_disassembly_decoder_with_labels #(
	parameter int TABLE_DEPTH    = 1024,
	parameter int TEXT_BASE_WORD = 3072
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,
	// request channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                req_type,
	input  logic [31:0]         instr_word,
	input  logic [9:0]          entry_index,
	// result channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic [5:0]          mnemonic,
	output logic [4:0]          reg_first,
	output logic [4:0]          reg_second,
	output logic [4:0]          reg_third,
	output logic signed [16:0]  imm_value,
	output logic [10:0]         label_number,
	output logic                target_error,
	output logic [15:0]         instr_position,
	output logic [10:0]         entry_label
);
	import mipsdd_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam logic [AW-1:0]    LAST_ADDR = AW'(TABLE_DEPTH - 1);
	localparam logic [TGT_W-1:0] DEPTH_T   = TGT_W'(TABLE_DEPTH);
	localparam logic [TGT_W-1:0] BASE_T    = TGT_W'(TEXT_BASE_WORD);

	// ---------------------------------------------------------------
	// Control state
	// ---------------------------------------------------------------
	state_t              state_q, state_nxt;
	logic [AW-1:0]       clr_addr_q;
	logic                trap_q;
	logic [15:0]         instr_cnt_q;
	logic [LABEL_W-1:0]  label_cnt_q;
	logic                out_valid_q;

	logic                accept;     // request taken this cycle
	logic                commit;     // result moves to output register
	logic                clr_done;

	assign accept   = in_valid && !in_stall;
	assign clr_done = (clr_addr_q == LAST_ADDR);

	// ---------------------------------------------------------------
	// Field extraction and decode of the incoming request
	// ---------------------------------------------------------------
	logic [5:0]  w_op, w_fn;
	logic [4:0]  w_rs, w_rt, w_rd;
	logic [15:0] w_i16;
	logic [25:0] w_i26;
	logic signed [16:0] w_simm, w_zimm;

	assign w_op  = instr_word[31:26];
	assign w_rs  = instr_word[25:21];
	assign w_rt  = instr_word[20:16];
	assign w_rd  = instr_word[15:11];
	assign w_fn  = instr_word[5:0];
	assign w_i16 = instr_word[15:0];
	assign w_i26 = instr_word[25:0];
	assign w_simm = $signed({w_i16[15], w_i16});
	assign w_zimm = $signed({1'b0, w_i16});

	mnem_t              dec_mn;
	logic [4:0]         dec_r1, dec_r2, dec_r3;
	logic signed [16:0] dec_imm;
	logic               dec_branch;   // target relative to the stream position
	logic               dec_jump;     // target from imm26

	always_comb begin
		dec_mn     = MN_UNKNOWN;
		dec_r1     = '0;
		dec_r2     = '0;
		dec_r3     = '0;
		dec_imm    = '0;
		dec_branch = 1'b0;
		dec_jump   = 1'b0;
		if (instr_word == '0) begin
			dec_mn = MN_NOP;
		end else if (instr_word == ERET_WORD) begin
			dec_mn = MN_ERET;
		end else if (w_op == OP_SPECIAL) begin
			case (w_fn)
				FN_ADD: begin
					dec_mn = trap_q ? MN_ADD : MN_ADDU;
					dec_r1 = w_rd; dec_r2 = w_rs; dec_r3 = w_rt;
				end
				FN_SUB: begin
					dec_mn = trap_q ? MN_SUB : MN_SUBU;
					dec_r1 = w_rd; dec_r2 = w_rs; dec_r3 = w_rt;
				end
				FN_AND:     begin dec_mn = MN_AND;  dec_r1 = w_rd; dec_r2 = w_rs; dec_r3 = w_rt; end
				FN_OR:      begin dec_mn = MN_OR;   dec_r1 = w_rd; dec_r2 = w_rs; dec_r3 = w_rt; end
				FN_SLT:     begin dec_mn = MN_SLT;  dec_r1 = w_rd; dec_r2 = w_rs; dec_r3 = w_rt; end
				FN_SLTU:    begin dec_mn = MN_SLTU; dec_r1 = w_rd; dec_r2 = w_rs; dec_r3 = w_rt; end
				FN_DIV:     begin dec_mn = MN_DIV;   dec_r1 = w_rs; dec_r2 = w_rt; end
				FN_DIVU:    begin dec_mn = MN_DIVU;  dec_r1 = w_rs; dec_r2 = w_rt; end
				FN_MULT:    begin dec_mn = MN_MULT;  dec_r1 = w_rs; dec_r2 = w_rt; end
				FN_MULTU:   begin dec_mn = MN_MULTU; dec_r1 = w_rs; dec_r2 = w_rt; end
				FN_JR:      begin dec_mn = MN_JR;   dec_r1 = w_rs; end
				FN_MTHI:    begin dec_mn = MN_MTHI; dec_r1 = w_rs; end
				FN_MTLO:    begin dec_mn = MN_MTLO; dec_r1 = w_rs; end
				FN_MFHI:    begin dec_mn = MN_MFHI; dec_r1 = w_rd; end
				FN_MFLO:    begin dec_mn = MN_MFLO; dec_r1 = w_rd; end
				FN_SYSCALL: begin dec_mn = MN_SYSCALL; end
				default:    begin dec_mn = MN_UNKNOWN; end
			endcase
		end else begin
			case (w_op)
				OP_ADDI: begin
					dec_mn = trap_q ? MN_ADDI : MN_ADDIU;
					dec_r1 = w_rt; dec_r2 = w_rs; dec_imm = w_simm;
				end
				OP_ANDI: begin dec_mn = MN_ANDI; dec_r1 = w_rt; dec_r2 = w_rs; dec_imm = w_zimm; end
				OP_ORI:  begin dec_mn = MN_ORI;  dec_r1 = w_rt; dec_r2 = w_rs; dec_imm = w_zimm; end
				OP_LUI:  begin dec_mn = MN_LUI;  dec_r1 = w_rt; dec_imm = w_zimm; end
				OP_BEQ: begin
					dec_mn = MN_BEQ; dec_r1 = w_rs; dec_r2 = w_rt; dec_imm = w_simm;
					dec_branch = 1'b1;
				end
				OP_BNE: begin
					dec_mn = MN_BNE; dec_r1 = w_rs; dec_r2 = w_rt; dec_imm = w_simm;
					dec_branch = 1'b1;
				end
				OP_LB: begin dec_mn = MN_LB; dec_r1 = w_rt; dec_r2 = w_rs; dec_imm = w_simm; end
				OP_LH: begin dec_mn = MN_LH; dec_r1 = w_rt; dec_r2 = w_rs; dec_imm = w_simm; end
				OP_LW: begin dec_mn = MN_LW; dec_r1 = w_rt; dec_r2 = w_rs; dec_imm = w_simm; end
				OP_SB: begin dec_mn = MN_SB; dec_r1 = w_rt; dec_r2 = w_rs; dec_imm = w_simm; end
				OP_SH: begin dec_mn = MN_SH; dec_r1 = w_rt; dec_r2 = w_rs; dec_imm = w_simm; end
				OP_SW: begin dec_mn = MN_SW; dec_r1 = w_rt; dec_r2 = w_rs; dec_imm = w_simm; end
				OP_J:   begin dec_mn = MN_J;   dec_jump = 1'b1; end
				OP_JAL: begin dec_mn = MN_JAL; dec_jump = 1'b1; end
				OP_COP0: begin
					if (w_rs == CP0_MF) begin
						dec_mn = MN_MFC0; dec_r1 = w_rt; dec_r2 = w_rd;
					end else if (w_rs == CP0_MT) begin
						dec_mn = MN_MTC0; dec_r1 = w_rt; dec_r2 = w_rd;
					end else begin
						dec_mn = MN_UNKNOWN;
					end
				end
				default: begin dec_mn = MN_UNKNOWN; end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Table index: branch target, jump target or read index.
	// Signed, wide enough that no case wraps.
	// ---------------------------------------------------------------
	logic signed [TGT_W-1:0] tgt;
	logic                    tgt_ok;
	logic                    dec_lookup;

	always_comb begin
		if (req_type == REQ_READ)
			tgt = $signed({{(TGT_W-10){1'b0}}, entry_index});
		else if (dec_jump)
			tgt = $signed({{(TGT_W-26){1'b0}}, w_i26}) - $signed(BASE_T);
		else
			tgt = $signed({{(TGT_W-16){1'b0}}, instr_cnt_q}) + TGT_W'(1)
			    + $signed({{(TGT_W-17){w_simm[16]}}, w_simm});
	end

	assign tgt_ok     = !tgt[TGT_W-1] && (tgt < $signed(DEPTH_T));
	assign dec_lookup = (req_type == REQ_DECODE) && (dec_branch || dec_jump);

	// ---------------------------------------------------------------
	// Stage 1 registers: decoded request while the table read is out
	// ---------------------------------------------------------------
	logic               read_s1;
	mnem_t              mn_s1;
	logic [4:0]         r1_s1, r2_s1, r3_s1;
	logic signed [16:0] imm_s1;
	logic               lookup_s1;
	logic               ok_s1;
	logic [AW-1:0]      addr_s1;
	logic [LABEL_W-1:0] label_rd_s1;   // memory read data

	always_ff @(posedge clk) begin
		if (accept) begin
			read_s1   <= req_type;
			mn_s1     <= dec_mn;
			r1_s1     <= dec_r1;
			r2_s1     <= dec_r2;
			r3_s1     <= dec_r3;
			imm_s1    <= dec_imm;
			lookup_s1 <= dec_lookup;
			ok_s1     <= tgt_ok;
			addr_s1   <= tgt[AW-1:0];
		end
	end

	// ---------------------------------------------------------------
	// Label table: one write port, one registered read port.
	// Only one request is in flight, so no read can overlap a pending write.
	// ---------------------------------------------------------------
	logic [LABEL_W-1:0] label_mem [TABLE_DEPTH];
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [LABEL_W-1:0] mem_wdata;

	always_ff @(posedge clk) begin
		if (mem_we)
			label_mem[mem_waddr] <= mem_wdata;
	end

	always_ff @(posedge clk) begin
		if (accept)
			label_rd_s1 <= label_mem[tgt[AW-1:0]];
	end

	// ---------------------------------------------------------------
	// Commit: allocate on first reference, build the result
	// ---------------------------------------------------------------
	logic               alloc;
	logic [LABEL_W-1:0] label_new;
	logic [LABEL_W-1:0] res_label;
	logic [LABEL_W-1:0] res_entry;

	assign alloc     = lookup_s1 && ok_s1 && (label_rd_s1 == '0);
	assign label_new = (label_cnt_q < LABEL_MAX) ? label_cnt_q + 1'b1 : label_cnt_q;

	always_comb begin
		res_label = '0;
		if (lookup_s1 && ok_s1)
			res_label = alloc ? label_new : label_rd_s1;
		res_entry = (read_s1 && ok_s1) ? label_rd_s1 : '0;
	end

	// ---------------------------------------------------------------
	// Sequencer: clearing pass, idle, lookup/commit
	// ---------------------------------------------------------------
	always_comb begin
		state_nxt = state_q;
		in_stall  = 1'b1;
		commit    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = addr_s1;
		mem_wdata = label_new;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = '0;
				if (clr_done)
					state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid)
					state_nxt = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				// wait here while the output register is full and held
				if (!out_valid_q || !out_stall) begin
					commit    = 1'b1;
					mem_we    = alloc;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			trap_q      <= 1'b1;
			instr_cnt_q <= '0;
			label_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_CLEAR)
				clr_addr_q <= clr_addr_q + 1'b1;
			if (cfg_wr_en)
				trap_q <= cfg_wr_data;
			if (commit && !read_s1)
				instr_cnt_q <= instr_cnt_q + 1'b1;
			if (commit && alloc)
				label_cnt_q <= label_new;
			if (commit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	logic [5:0]         mn_q;
	logic [4:0]         r1_q, r2_q, r3_q;
	logic signed [16:0] imm_q;
	logic [LABEL_W-1:0] label_q, entry_q;
	logic               err_q;
	logic [15:0]        pos_q;

	always_ff @(posedge clk) begin
		if (commit) begin
			if (read_s1) begin
				mn_q    <= '0;
				r1_q    <= '0;
				r2_q    <= '0;
				r3_q    <= '0;
				imm_q   <= '0;
				label_q <= '0;
				err_q   <= 1'b0;
				pos_q   <= '0;
			end else begin
				mn_q    <= mn_s1;
				r1_q    <= r1_s1;
				r2_q    <= r2_s1;
				r3_q    <= r3_s1;
				imm_q   <= imm_s1;
				label_q <= res_label;
				err_q   <= lookup_s1 && !ok_s1;
				pos_q   <= instr_cnt_q;
			end
			entry_q <= res_entry;
		end
	end

	assign out_valid      = out_valid_q;
	assign mnemonic       = mn_q;
	assign reg_first      = r1_q;
	assign reg_second     = r2_q;
	assign reg_third      = r3_q;
	assign imm_value      = imm_q;
	assign label_number   = label_q;
	assign target_error   = err_q;
	assign instr_position = pos_q;
	assign entry_label    = entry_q;

endmodule
